// ----- rtl/idmap_pkg.sv -----
// Package with the command, status and state codes and the field widths of the id allocator.
package idmap_pkg;

	localparam int IDENT_W  = 10;
	localparam int LOC_W    = 32;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 48;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC     = 2'd0,
		CMD_FREE      = 2'd1,
		CMD_TRANSLATE = 2'd2,
		CMD_RENAME    = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE   = 2'd0,
		STAT_BAD_ID = 2'd1,
		STAT_FULL   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

// ----- rtl/id_allocator_with_translation_map_unit.sv -----
// Top level of the id allocator with its translation map and free id stack.
//
// The input channel (s_*) carries one command per beat: tuser holds the command,
// tdata the identifier and the location word. The output channel (m_*) returns one
// result beat per command: tuser holds the status, tdata the allocated identifier
// and the location found by a translate.
// The accepting edge issues the reads of the free stack and the location map. In
// the write-back state the block writes the changed memory entries and loads the
// result register, which waits while a result beat is held. The block takes no new
// command until the previous one has been written back, as the read and write-back
// go over the two synchronous memories.
// After reset the block clears the location map one entry per cycle; s_tready stays
// low until that pass is over.
// When the receiver stalls, the result register holds its beat. One further
// command may be accepted; it waits in its write-back step until the held beat
// has been taken.
module id_allocator_with_translation_map_unit
	import idmap_pkg::*;
#(
	parameter int ID_COUNT = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // ident [9:0], location [41:10], zeros
	input  logic [CMD_W-1:0]    s_tuser,  // cmd [1:0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // new_ident [9:0], found_location [41:10], zeros
	output logic [STATUS_W-1:0] m_tuser   // status [1:0]
);

	localparam int AW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
	localparam int IW = $clog2(ID_COUNT + 1);
	localparam int CW = (IW > IDENT_W) ? IW : IDENT_W;
	localparam logic [CW-1:0] ID_LIMIT = CW'(ID_COUNT);
	localparam logic [AW-1:0] LAST_ENTRY = AW'(ID_COUNT - 1);

	state_t state_q, state_d;

	logic [AW-1:0]      clr_q;
	logic [IW-1:0]      depth_q;
	logic [IW-1:0]      fresh_q;
	cmd_t               cmd_q;
	logic [IDENT_W-1:0] ident_q;
	logic [LOC_W-1:0]   loc_q;
	logic               out_valid_q;
	logic [M_DATA_W-1:0] out_data_q;
	logic [STATUS_W-1:0] out_user_q;

	logic               accept;
	logic               commit;
	logic [CW-1:0]      in_ident_ext;
	logic [CW-1:0]      ident_ext;
	logic               ident_ok;

	logic               map_we;
	logic [AW-1:0]      map_waddr;
	logic [LOC_W-1:0]   map_wdata;
	logic [LOC_W-1:0]   map_rdata;
	logic               stk_we;
	logic [AW-1:0]      stk_raddr;
	logic [AW-1:0]      stk_rdata;

	logic [AW-1:0]      given;
	logic [LOC_W-1:0]   found;
	status_t            status;
	logic               pop;
	logic               take_fresh;
	logic               push;

	assign accept       = s_tvalid && s_tready;
	assign commit       = (state_q == ST_EXEC) && (!out_valid_q || m_tready);
	assign in_ident_ext = CW'(s_tdata[IDENT_W-1:0]);
	assign ident_ext    = CW'(ident_q);
	assign ident_ok     = (ident_ext != '0) && (ident_ext < ID_LIMIT);
	assign stk_raddr    = AW'(depth_q - IW'(1));

	idmap_ram #(
		.WIDTH(LOC_W),
		.DEPTH(ID_COUNT)
	) u_map (
		.clk  (clk),
		.we   (map_we),
		.waddr(map_waddr),
		.wdata(map_wdata),
		.re   (accept),
		.raddr(in_ident_ext[AW-1:0]),
		.rdata(map_rdata)
	);

	idmap_ram #(
		.WIDTH(AW),
		.DEPTH(ID_COUNT)
	) u_stack (
		.clk  (clk),
		.we   (stk_we),
		.waddr(depth_q[AW-1:0]),
		.wdata(ident_ext[AW-1:0]),
		.re   (accept),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_ENTRY) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (commit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		s_tready   = (state_q == ST_IDLE);
		given      = '0;
		found      = '0;
		status     = STAT_DONE;
		pop        = 1'b0;
		take_fresh = 1'b0;
		push       = 1'b0;
		map_we     = 1'b0;
		map_waddr  = ident_ext[AW-1:0];
		map_wdata  = loc_q;
		case (state_q)
			ST_CLEAR: begin
				map_we    = 1'b1;
				map_waddr = clr_q;
				map_wdata = '0;
			end
			ST_EXEC: begin
				if (cmd_q == CMD_ALLOC) begin
					if (depth_q != '0) begin
						pop       = 1'b1;
						given     = stk_rdata;
						map_waddr = stk_rdata;
						map_we    = (CW'(stk_rdata) != '0) && (CW'(stk_rdata) < ID_LIMIT);
					end else if (CW'(fresh_q) < ID_LIMIT) begin
						take_fresh = 1'b1;
						given      = fresh_q[AW-1:0];
						map_waddr  = fresh_q[AW-1:0];
						map_we     = 1'b1;
					end else begin
						status = STAT_FULL;
					end
				end else if (!ident_ok) begin
					status = STAT_BAD_ID;
				end else begin
					case (cmd_q)
						CMD_FREE: begin
							map_we    = 1'b1;
							map_wdata = '0;
							if (CW'(depth_q) < ID_LIMIT) begin
								push = 1'b1;
							end else begin
								status = STAT_FULL;
							end
						end
						CMD_TRANSLATE: found = map_rdata;
						CMD_RENAME:    map_we = 1'b1;
						default:       map_we = 1'b0;
					endcase
				end
				map_we = map_we && commit;
			end
			default: map_we = 1'b0;
		endcase
		stk_we = push && commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			depth_q     <= '0;
			fresh_q     <= IW'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (commit) begin
				if (pop) begin
					depth_q <= depth_q - IW'(1);
				end else if (push) begin
					depth_q <= depth_q + IW'(1);
				end
				if (take_fresh) begin
					fresh_q <= fresh_q + IW'(1);
				end
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd_t'(s_tuser);
			ident_q <= s_tdata[IDENT_W-1:0];
			loc_q   <= s_tdata[IDENT_W+LOC_W-1:IDENT_W];
		end
		if (commit) begin
			out_data_q <= M_DATA_W'({found, IDENT_W'(given)});
			out_user_q <= status;
		end
	end

	always_comb begin
		m_tvalid = out_valid_q;
		m_tdata  = out_data_q;
		m_tuser  = out_user_q;
	end

endmodule

// ----- rtl/idmap_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module idmap_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/idmap_checker.sv -----
// Port checker for the id allocator, bound to its top level.
module idmap_checker
	import idmap_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic [STATUS_W-1:0] m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Stalled result beat changed or vanished.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Command accepted before the previous one was written back.");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != STAT_DONE) |-> (m_tdata == '0))
		else $error("Failed command returned nonzero data.");

	a_alloc_no_loc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[IDENT_W-1:0] != '0) |->
		(m_tdata[IDENT_W+LOC_W-1:IDENT_W] == '0) && (m_tuser == STAT_DONE))
		else $error("Allocation result carried a location word.");

endmodule

bind id_allocator_with_translation_map_unit idmap_checker u_idmap_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
